### hdl/sbe_pkg.sv
// Shared codes and controller/datapath handshake types for the basis expansion unit.
package sbe_pkg;

  // Input transaction modes
  localparam logic [1:0] MODE_LOAD_POLY  = 2'd0;
  localparam logic [1:0] MODE_LOAD_BASIS = 2'd1;
  localparam logic [1:0] MODE_START      = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd1;
  localparam logic [1:0] STATUS_SAT      = 2'd2;

  // Register indexes (taken from paddr[2])
  localparam logic REG_POLY_LENGTH = 1'b0;
  localparam logic REG_BASIS_SIZE  = 1'b1;

  localparam int CFG_WIDTH = 5;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_poly;
    logic load_basis;
    logic clr_sat;
    logic copy_we;
    logic div_go;
    logic coef_we;
    logic mul_go;
    logic upd_we;
    logic emit;
    logic emit_err;
    logic emit_zero;
    logic emit_last;
  } sbe_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic div_done;
    logic mul_done;
  } sbe_sts_t;

endpackage

### hdl/sbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sbe_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/sbe_ctrl.sv
// Sequencer for copy, divide, multiply-subtract and result phases.
module sbe_ctrl #(
  parameter int MAX_TERMS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  input  logic [1:0]                              in_mode,
  input  logic [sbe_pkg::CFG_WIDTH-1:0]           poly_length,
  input  logic [sbe_pkg::CFG_WIDTH-1:0]           basis_size,
  input  sbe_pkg::sbe_sts_t                       sts,
  output sbe_pkg::sbe_cmd_t                       cmd,
  output logic                                    busy,
  output logic [$clog2(MAX_TERMS)-1:0]            rem_raddr,
  output logic [$clog2(MAX_TERMS)-1:0]            work_raddr,
  output logic [$clog2(MAX_TERMS)-1:0]            work_waddr,
  output logic [$clog2(MAX_TERMS*MAX_TERMS)-1:0]  basis_raddr,
  output logic [$clog2(MAX_TERMS)-1:0]            coef_raddr,
  output logic [$clog2(MAX_TERMS)-1:0]            coef_waddr,
  output logic [3:0]                              emit_idx
);
  import sbe_pkg::*;

  localparam int AW  = $clog2(MAX_TERMS);
  localparam int CW  = $clog2(MAX_TERMS + 1);
  localparam int BAW = $clog2(MAX_TERMS * MAX_TERMS);

  typedef enum logic [3:0] {
    S_IDLE, S_ERR, S_CPY_RD, S_CPY_WR, S_DIV_RD, S_DIV_GO, S_DIV_WAIT,
    S_UPD_RD, S_UPD_GO, S_UPD_WAIT, S_UPD_WR, S_OUT_RD, S_OUT_EMIT
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] p_r, p_nxt, b_r, b_nxt;
  logic [AW-1:0] r_r, r_nxt, l_r, l_nxt;
  logic [7:0]    plen_w, bsz_w, p_w, b_w;
  logic [CW-1:0] rem_idx;

  // Clamp register values to the supported range
  always_comb begin
    plen_w = 8'(poly_length);
    bsz_w  = 8'(basis_size);
    p_w    = (plen_w > 8'(MAX_TERMS)) ? 8'(MAX_TERMS) : plen_w;
    b_w    = (bsz_w > 8'(MAX_TERMS)) ? 8'(MAX_TERMS) : bsz_w;
    if (b_w == 8'd0) begin
      b_w = 8'd1;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    p_nxt     = p_r;
    b_nxt     = b_r;
    r_nxt     = r_r;
    l_nxt     = l_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.load_poly  = start && (in_mode == MODE_LOAD_POLY);
        cmd.load_basis = start && (in_mode == MODE_LOAD_BASIS);
        if (start && (in_mode == MODE_START)) begin
          p_nxt = CW'(p_w);
          b_nxt = CW'(b_w);
          l_nxt = '0;
          if (p_w > b_w) begin
            state_nxt = S_ERR;
          end else begin
            cmd.clr_sat = 1'b1;
            state_nxt   = (p_w == 8'd0) ? S_OUT_RD : S_CPY_RD;
          end
        end
      end
      S_ERR: begin
        cmd.emit      = 1'b1;
        cmd.emit_err  = 1'b1;
        cmd.emit_last = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_CPY_RD: begin
        state_nxt = S_CPY_WR;
      end
      S_CPY_WR: begin
        cmd.copy_we = 1'b1;
        if (CW'(l_r) == p_r - CW'(1)) begin
          r_nxt     = AW'(p_r - CW'(1));
          l_nxt     = '0;
          state_nxt = S_DIV_RD;
        end else begin
          l_nxt     = l_r + AW'(1);
          state_nxt = S_CPY_RD;
        end
      end
      S_DIV_RD: begin
        state_nxt = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_go = 1'b1;
        state_nxt  = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.coef_we = 1'b1;
          l_nxt       = '0;
          state_nxt   = (r_r == '0) ? S_OUT_RD : S_UPD_RD;
        end
      end
      S_UPD_RD: begin
        state_nxt = S_UPD_GO;
      end
      S_UPD_GO: begin
        cmd.mul_go = 1'b1;
        state_nxt  = S_UPD_WAIT;
      end
      S_UPD_WAIT: begin
        if (sts.mul_done) begin
          state_nxt = S_UPD_WR;
        end
      end
      S_UPD_WR: begin
        cmd.upd_we = 1'b1;
        if (l_r == r_r - AW'(1)) begin
          r_nxt     = r_r - AW'(1);
          l_nxt     = '0;
          state_nxt = S_DIV_RD;
        end else begin
          l_nxt     = l_r + AW'(1);
          state_nxt = S_UPD_RD;
        end
      end
      S_OUT_RD: begin
        state_nxt = S_OUT_EMIT;
      end
      S_OUT_EMIT: begin
        cmd.emit      = 1'b1;
        cmd.emit_zero = !(CW'(l_r) < p_r);
        cmd.emit_last = (CW'(l_r) == b_r - CW'(1));
        if (cmd.emit_last) begin
          state_nxt = S_IDLE;
        end else begin
          l_nxt     = l_r + AW'(1);
          state_nxt = S_OUT_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      p_r     <= '0;
      b_r     <= '0;
      r_r     <= '0;
      l_r     <= '0;
    end else begin
      state_r <= state_nxt;
      p_r     <= p_nxt;
      b_r     <= b_nxt;
      r_r     <= r_nxt;
      l_r     <= l_nxt;
    end
  end

  // Memory addresses
  assign rem_idx     = p_r - CW'(1) - CW'(l_r);
  assign rem_raddr   = AW'(rem_idx);
  assign work_raddr  = (state_r == S_DIV_RD) ? r_r : l_r;
  assign work_waddr  = l_r;
  assign basis_raddr = BAW'(r_r) * BAW'(MAX_TERMS)
                     + ((state_r == S_DIV_RD) ? BAW'(r_r) : BAW'(l_r));
  assign coef_raddr  = l_r;
  assign coef_waddr  = r_r;
  assign emit_idx    = 4'(l_r);
  assign busy        = (state_r != S_IDLE);

endmodule

### hdl/sbe_dp.sv
// Datapath: stores, serial divider, split multiplier, saturating subtract, result register.
module sbe_dp #(
  parameter int MAX_TERMS  = 16,
  parameter int WORD_WIDTH = 64,
  parameter int FRAC_BITS  = 56
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  sbe_pkg::sbe_cmd_t                       cmd,
  output sbe_pkg::sbe_sts_t                       sts,
  input  logic [3:0]                              in_row,
  input  logic [3:0]                              in_col,
  input  logic signed [63:0]                      in_value,
  input  logic [$clog2(MAX_TERMS)-1:0]            rem_raddr,
  input  logic [$clog2(MAX_TERMS)-1:0]            work_raddr,
  input  logic [$clog2(MAX_TERMS)-1:0]            work_waddr,
  input  logic [$clog2(MAX_TERMS*MAX_TERMS)-1:0]  basis_raddr,
  input  logic [$clog2(MAX_TERMS)-1:0]            coef_raddr,
  input  logic [$clog2(MAX_TERMS)-1:0]            coef_waddr,
  input  logic [3:0]                              emit_idx,
  output logic                                    out_valid,
  output logic [3:0]                              out_coef_index,
  output logic signed [63:0]                      out_coef_value,
  output logic [1:0]                              out_status,
  output logic                                    out_last
);
  import sbe_pkg::*;

  localparam int W   = WORD_WIDTH;
  localparam int AW  = $clog2(MAX_TERMS);
  localparam int BAW = $clog2(MAX_TERMS * MAX_TERMS);
  localparam int NB  = WORD_WIDTH + FRAC_BITS;   // dividend bits
  localparam int DX  = NB + 1;                    // rounded quotient bits
  localparam int MX  = 2 * WORD_WIDTH + 1;        // rounded product bits
  localparam int H   = (WORD_WIDTH + 1) / 2;      // multiplier split point
  localparam int DCW = $clog2(NB + 1);
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  // ---------------- stores ----------------
  logic          row_ok, col_ok, rem_we, basis_we, work_we;
  logic [W-1:0]  load_val, rem_rdata, basis_rdata, work_rdata, work_wdata, coef_rdata;
  logic [BAW-1:0] basis_waddr;

  assign row_ok      = 8'(in_row) < 8'(MAX_TERMS);
  assign col_ok      = 8'(in_col) < 8'(MAX_TERMS);
  assign rem_we      = cmd.load_poly && row_ok;
  assign basis_we    = cmd.load_basis && row_ok && col_ok && (in_col <= in_row);
  assign basis_waddr = BAW'(in_row) * BAW'(MAX_TERMS) + BAW'(in_col);
  assign load_val    = in_value[W-1:0];

  sbe_ram #(.WIDTH(W), .DEPTH(MAX_TERMS)) u_rem (
    .clk(clk), .we(rem_we), .waddr(AW'(in_row)), .wdata(load_val),
    .raddr(rem_raddr), .rdata(rem_rdata)
  );

  sbe_ram #(.WIDTH(W), .DEPTH(MAX_TERMS * MAX_TERMS)) u_basis (
    .clk(clk), .we(basis_we), .waddr(basis_waddr), .wdata(load_val),
    .raddr(basis_raddr), .rdata(basis_rdata)
  );

  sbe_ram #(.WIDTH(W), .DEPTH(MAX_TERMS)) u_work (
    .clk(clk), .we(work_we), .waddr(work_waddr), .wdata(work_wdata),
    .raddr(work_raddr), .rdata(work_rdata)
  );

  logic [W-1:0] q_r;

  sbe_ram #(.WIDTH(W), .DEPTH(MAX_TERMS)) u_coef (
    .clk(clk), .we(cmd.coef_we), .waddr(coef_waddr), .wdata(q_r),
    .raddr(coef_raddr), .rdata(coef_rdata)
  );

  // ---------------- divider: one quotient bit per cycle ----------------
  logic [W-1:0]   n_mag, d_mag;
  logic           dv_run_r, dv_rnd_r, dv_sat_r, dv_done_r;
  logic [DCW-1:0] dcnt_r;
  logic [W-1:0]   dd_r, drem_r;
  logic [NB-1:0]  num_r;
  logic [DX-1:0]  qx_r;
  logic           qneg_r;
  logic [W:0]     trial;
  logic           ge, rnd_up;
  logic           dv_over;
  logic [W-1:0]   dv_res;
  logic           dz_sat;

  assign n_mag  = work_rdata[W-1] ? (W'(0) - work_rdata) : work_rdata;
  assign d_mag  = basis_rdata[W-1] ? (W'(0) - basis_rdata) : basis_rdata;
  assign trial  = {drem_r, num_r[NB-1]};
  assign ge     = trial >= {1'b0, dd_r};
  assign rnd_up = {drem_r, 1'b0} >= {1'b0, dd_r};
  assign dz_sat = cmd.div_go && (d_mag == '0);

  // Saturate the rounded quotient magnitude
  always_comb begin
    dv_over = (qx_r[DX-1:W-1] != '0) && !(qneg_r && (qx_r == (DX'(1) << (W-1))));
    if (dv_over) begin
      dv_res = qneg_r ? MINV : MAXV;
    end else begin
      dv_res = qneg_r ? (W'(0) - W'(qx_r)) : W'(qx_r);
    end
  end

  // ---------------- multiplier: four partial products ----------------
  logic [W-1:0]   ma_r, mb_r, wl_r, prod_r;
  logic [1:0]     mcnt_r;
  logic           mu_run_r, mu_rnd_r, mu_sat_r, mu_done_r, pneg_r;
  logic [2*W-1:0] acc_r, pp_sh;
  logic [MX-1:0]  mr_r;
  logic [H-1:0]   a_part, b_part;
  logic [2*H-1:0] pp;
  logic           mu_over;
  logic [W-1:0]   mu_res;

  always_comb begin
    a_part = mcnt_r[0] ? H'(ma_r >> H) : H'(ma_r);
    b_part = mcnt_r[1] ? H'(mb_r >> H) : H'(mb_r);
    pp     = (2*H)'(a_part) * (2*H)'(b_part);
    case (mcnt_r)
      2'd0:    pp_sh = (2*W)'(pp);
      2'd3:    pp_sh = (2*W)'(pp) << (2*H);
      default: pp_sh = (2*W)'(pp) << H;
    endcase
  end

  // Saturate the rounded product magnitude
  always_comb begin
    mu_over = (mr_r[MX-1:W-1] != '0) && !(pneg_r && (mr_r == (MX'(1) << (W-1))));
    if (mu_over) begin
      mu_res = pneg_r ? MINV : MAXV;
    end else begin
      mu_res = pneg_r ? (W'(0) - W'(mr_r)) : W'(mr_r);
    end
  end

  // ---------------- saturating subtract ----------------
  logic [W:0]   diff;
  logic         sub_ovf;
  logic [W-1:0] upd_val;

  assign diff    = {wl_r[W-1], wl_r} - {prod_r[W-1], prod_r};
  assign sub_ovf = diff[W] != diff[W-1];
  assign upd_val = sub_ovf ? (diff[W] ? MINV : MAXV) : diff[W-1:0];

  assign work_we    = cmd.copy_we || cmd.upd_we;
  assign work_wdata = cmd.copy_we ? rem_rdata : upd_val;

  assign sts.div_done = dv_done_r;
  assign sts.mul_done = mu_done_r;

  // ---------------- control flags ----------------
  logic sat_r;
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_run_r    <= 1'b0;
      dv_rnd_r    <= 1'b0;
      dv_sat_r    <= 1'b0;
      dv_done_r   <= 1'b0;
      mu_run_r    <= 1'b0;
      mu_rnd_r    <= 1'b0;
      mu_sat_r    <= 1'b0;
      mu_done_r   <= 1'b0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
      dcnt_r      <= '0;
      mcnt_r      <= '0;
    end else begin
      // divider sequencing
      dv_done_r <= 1'b0;
      if (cmd.div_go) begin
        if (d_mag == '0) begin
          dv_done_r <= 1'b1;
        end else begin
          dv_run_r <= 1'b1;
          dcnt_r   <= DCW'(NB);
        end
      end else if (dv_run_r) begin
        dcnt_r <= dcnt_r - DCW'(1);
        if (dcnt_r == DCW'(1)) begin
          dv_run_r <= 1'b0;
          dv_rnd_r <= 1'b1;
        end
      end else if (dv_rnd_r) begin
        dv_rnd_r <= 1'b0;
        dv_sat_r <= 1'b1;
      end else if (dv_sat_r) begin
        dv_sat_r  <= 1'b0;
        dv_done_r <= 1'b1;
      end
      // multiplier sequencing
      mu_done_r <= 1'b0;
      if (cmd.mul_go) begin
        mu_run_r <= 1'b1;
        mcnt_r   <= '0;
      end else if (mu_run_r) begin
        mcnt_r <= mcnt_r + 2'd1;
        if (mcnt_r == 2'd3) begin
          mu_run_r <= 1'b0;
          mu_rnd_r <= 1'b1;
        end
      end else if (mu_rnd_r) begin
        mu_rnd_r <= 1'b0;
        mu_sat_r <= 1'b1;
      end else if (mu_sat_r) begin
        mu_sat_r  <= 1'b0;
        mu_done_r <= 1'b1;
      end
      // run-wide saturation flag
      if (cmd.clr_sat) begin
        sat_r <= 1'b0;
      end else if (dz_sat || (dv_sat_r && dv_over) || (mu_sat_r && mu_over)
                   || (cmd.upd_we && sub_ovf)) begin
        sat_r <= 1'b1;
      end
      out_valid_r <= cmd.emit;
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    // divider operands and iteration
    if (cmd.div_go) begin
      dd_r   <= d_mag;
      drem_r <= '0;
      num_r  <= {n_mag, {FRAC_BITS{1'b0}}};
      qneg_r <= work_rdata[W-1] ^ basis_rdata[W-1];
      if (d_mag == '0) begin
        if (n_mag == '0) begin
          q_r <= '0;
        end else begin
          q_r <= work_rdata[W-1] ? MINV : MAXV;
        end
      end
    end else if (dv_run_r) begin
      drem_r <= ge ? W'(trial - {1'b0, dd_r}) : W'(trial);
      num_r  <= {num_r[NB-2:0], ge};
    end else if (dv_rnd_r) begin
      qx_r <= DX'(num_r) + DX'(rnd_up);
    end else if (dv_sat_r) begin
      q_r <= dv_res;
    end
    // multiplier operands and accumulation
    if (cmd.mul_go) begin
      ma_r   <= q_r[W-1] ? (W'(0) - q_r) : q_r;
      mb_r   <= d_mag;
      pneg_r <= q_r[W-1] ^ basis_rdata[W-1];
      wl_r   <= work_rdata;
      acc_r  <= '0;
    end else if (mu_run_r) begin
      acc_r <= acc_r + pp_sh;
    end else if (mu_rnd_r) begin
      mr_r <= (MX'(acc_r) + (MX'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    end else if (mu_sat_r) begin
      prod_r <= mu_res;
    end
    // result register
    if (cmd.emit) begin
      out_coef_index <= cmd.emit_err ? 4'd0 : emit_idx;
      out_coef_value <= (cmd.emit_err || cmd.emit_zero) ? 64'sd0 : 64'($signed(coef_rdata));
      out_status     <= cmd.emit_err ? STATUS_TOO_LONG : (sat_r ? STATUS_SAT : STATUS_OK);
      out_last       <= cmd.emit_last;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### hdl/schur_basis_expansion_unit.sv
// Top level: register port, controller and datapath of the basis expansion unit.
// Load transactions are taken while the unit is idle; busy stays low afterwards.
// A start transaction keeps busy high while the serial divider and the four-pass multiplier work.
// Results are not back-to-back: each is read from the coefficient store, then registered; no stall.
// Synchronous active-low reset clears the controller and flags and sets poly_length to 1 and
// basis_size to 16; stores and datapath payload registers are not cleared.
module schur_basis_expansion_unit #(
  parameter int MAX_TERMS  = 16,
  parameter int WORD_WIDTH = 64,
  parameter int FRAC_BITS  = 56
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic [3:0]         in_row,
  input  logic [3:0]         in_col,
  input  logic signed [63:0] in_value,
  output logic               out_valid,
  output logic [3:0]         out_coef_index,
  output logic signed [63:0] out_coef_value,
  output logic [1:0]         out_status,
  output logic               out_last,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import sbe_pkg::*;

  localparam int AW  = $clog2(MAX_TERMS);
  localparam int BAW = $clog2(MAX_TERMS * MAX_TERMS);

  logic [CFG_WIDTH-1:0] poly_length_r, basis_size_r;
  logic                 cfg_wr;

  // Register writes and reads
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_length_r <= CFG_WIDTH'(1);
      basis_size_r  <= CFG_WIDTH'(16);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_POLY_LENGTH) begin
        poly_length_r <= pwdata[CFG_WIDTH-1:0];
      end else begin
        basis_size_r <= pwdata[CFG_WIDTH-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_BASIS_SIZE) ? 32'(basis_size_r) : 32'(poly_length_r);

  sbe_cmd_t       cmd;
  sbe_sts_t       sts;
  logic [AW-1:0]  rem_raddr, work_raddr, work_waddr, coef_raddr, coef_waddr;
  logic [BAW-1:0] basis_raddr;
  logic [3:0]     emit_idx;

  sbe_ctrl #(.MAX_TERMS(MAX_TERMS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_mode(in_mode),
    .poly_length(poly_length_r), .basis_size(basis_size_r),
    .sts(sts), .cmd(cmd), .busy(busy),
    .rem_raddr(rem_raddr), .work_raddr(work_raddr), .work_waddr(work_waddr),
    .basis_raddr(basis_raddr), .coef_raddr(coef_raddr), .coef_waddr(coef_waddr),
    .emit_idx(emit_idx)
  );

  sbe_dp #(
    .MAX_TERMS(MAX_TERMS), .WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_row(in_row), .in_col(in_col), .in_value(in_value),
    .rem_raddr(rem_raddr), .work_raddr(work_raddr), .work_waddr(work_waddr),
    .basis_raddr(basis_raddr), .coef_raddr(coef_raddr), .coef_waddr(coef_waddr),
    .emit_idx(emit_idx),
    .out_valid(out_valid), .out_coef_index(out_coef_index),
    .out_coef_value(out_coef_value), .out_status(out_status), .out_last(out_last)
  );

endmodule

### hdl/sbe_chk.sv
// Port-level checks for the basis expansion unit, bound to the top level.
module sbe_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [1:0]         in_mode,
  input logic               out_valid,
  input logic [3:0]         out_coef_index,
  input logic signed [63:0] out_coef_value,
  input logic [1:0]         out_status,
  input logic               out_last
);
  import sbe_pkg::*;

  // Results never come in consecutive cycles
  a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back results");

  // More results follow while the unit stays busy
  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("unit idle in the middle of a run");

  // A too-long run yields one zero result at index 0
  a_too_long: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STATUS_TOO_LONG))
      |-> (out_last && (out_coef_value == 64'sd0) && (out_coef_index == 4'd0)))
    else $error("malformed too-long result");

  // A start transaction always occupies the unit
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_mode == MODE_START)) |=> busy)
    else $error("start transaction did not take the unit busy");

endmodule

bind schur_basis_expansion_unit sbe_chk u_sbe_chk (.*);

### test/tb_schur_basis_expansion_unit.sv
// Self-checking testbench for the fixed-point basis expansion unit.
`timescale 1ns / 100ps

module tb_schur_basis_expansion_unit;
  import sbe_pkg::*;

  localparam int          NTERMS    = 16;
  localparam int          SETTLE    = 24;
  localparam int          LIMIT     = 3000000;
  localparam logic [63:0] Q_ONE     = 64'h0100_0000_0000_0000;
  localparam logic [63:0] Q_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Q_MIN     = 64'h8000_0000_0000_0000;
  localparam logic [2:0]  ADDR_PLEN = {REG_POLY_LENGTH, 2'b00};
  localparam logic [2:0]  ADDR_BSZ  = {REG_BASIS_SIZE, 2'b00};
  localparam logic [1:0]  MODE_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [63:0] value;
  } cmd_item_t;

  typedef struct packed {
    logic [3:0]  index;
    logic [63:0] value;
    logic [1:0]  status;
    logic        last;
  } coef_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_mode = '0;
  logic [3:0] in_row = '0;
  logic [3:0] in_col = '0;
  logic signed [63:0] in_value = '0;
  logic out_valid;
  logic [3:0] out_coef_index;
  logic signed [63:0] out_coef_value;
  logic [1:0] out_status;
  logic out_last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  schur_basis_expansion_unit dut (.*);

  always #4 clk = ~clk;

  // Predictor state
  logic [63:0] poly_mem [NTERMS];
  logic [63:0] basis_mem [NTERMS][NTERMS];
  logic [4:0]  cfg_plen = 5'd1;
  logic [4:0]  cfg_bsize = 5'd16;
  bit          sat_hit;

  // Generator bookkeeping
  bit poly_set [NTERMS];
  bit basis_set [NTERMS][NTERMS];

  cmd_item_t pending_q[$];
  coef_t     coef_q[$];
  cmd_item_t cur;
  int        gap_left = 0;
  bit        gaps_on = 1'b1;
  int        items_pushed = 0;
  int        errors = 0;
  int        runs_done = 0;
  int        sat_runs = 0;
  int        checked = 0;
  int        cycles = 0;

  // Fixed-point helpers
  function automatic logic [63:0] mag_of(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic logic [63:0] sat_word(bit neg, logic [127:0] mag);
    logic [127:0] lim;
    lim = neg ? {64'd0, Q_MIN} : {64'd0, Q_MAX};
    if (mag > lim) begin
      sat_hit = 1'b1;
      mag = lim;
    end
    return neg ? -mag[63:0] : mag[63:0];
  endfunction

  function automatic logic [63:0] q_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] pr;
    pr = {64'd0, mag_of(a)} * {64'd0, mag_of(b)};
    pr = pr + (128'd1 << 55);
    return sat_word(a[63] ^ b[63], pr >> 56);
  endfunction

  function automatic logic [63:0] q_div(logic [63:0] n, logic [63:0] d);
    logic [127:0] num, den, q, r;
    if (mag_of(d) == 0) begin
      sat_hit = 1'b1;
      if (mag_of(n) == 0) return 64'd0;
      return sat_word(n[63], 128'd1 << 64);
    end
    num = {64'd0, mag_of(n)} << 56;
    den = {64'd0, mag_of(d)};
    q = num / den;
    r = num % den;
    if (r >= den - r) q = q + 1;
    return sat_word(n[63] ^ d[63], q);
  endfunction

  function automatic logic [63:0] q_sub(logic [63:0] a, logic [63:0] b);
    logic signed [64:0] s;
    s = $signed({a[63], a}) - $signed({b[63], b});
    if (s > $signed({1'b0, Q_MAX})) begin
      sat_hit = 1'b1;
      return Q_MAX;
    end
    if (s < $signed({1'b1, Q_MIN})) begin
      sat_hit = 1'b1;
      return Q_MIN;
    end
    return s[63:0];
  endfunction

  function automatic int eff_plen(logic [4:0] v);
    return (v > NTERMS) ? NTERMS : v;
  endfunction

  function automatic int eff_bsize(logic [4:0] v);
    if (v == 0) return 1;
    return (v > NTERMS) ? NTERMS : v;
  endfunction

  // Back-substitution: queue the coefficients one start transaction yields
  task automatic expand_poly();
    logic [63:0] work [NTERMS];
    logic [63:0] coefs [NTERMS];
    logic [1:0]  st;
    int p, b, r;
    p = eff_plen(cfg_plen);
    b = eff_bsize(cfg_bsize);
    runs_done++;
    if (p > b) begin
      coef_q.push_back('{4'd0, 64'd0, STATUS_TOO_LONG, 1'b1});
      return;
    end
    sat_hit = 1'b0;
    for (int l = 0; l < NTERMS; l++) coefs[l] = '0;
    for (int l = 0; l < p; l++) work[l] = poly_mem[p - 1 - l];
    for (int k = p; k > 0; k--) begin
      r = k - 1;
      coefs[r] = q_div(work[r], basis_mem[r][r]);
      for (int l = 0; l < r; l++)
        work[l] = q_sub(work[l], q_mul(coefs[r], basis_mem[r][l]));
    end
    st = sat_hit ? STATUS_SAT : STATUS_OK;
    if (sat_hit) sat_runs++;
    for (int l = 0; l < b; l++)
      coef_q.push_back('{l[3:0], coefs[l], st, l == b - 1});
  endtask

  task automatic apply_item(cmd_item_t it);
    case (it.mode)
      MODE_LOAD_POLY: poly_mem[it.row] = it.value;
      MODE_LOAD_BASIS: if (it.col <= it.row) basis_mem[it.row][it.col] = it.value;
      MODE_START: expand_poly();
      default: ;
    endcase
  endtask

  // Driver: one transaction per accept, random idle bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) apply_item(cur);
      if (start && busy) begin
        // hold the transaction until accepted
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
        gap_left <= $urandom_range(0, 18);
        start <= 1'b0;
      end else if (pending_q.size() > 0) begin
        cur = pending_q.pop_front();
        in_mode <= cur.mode;
        in_row <= cur.row;
        in_col <= cur.col;
        in_value <= cur.value;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("ERROR t=%0t %s: got %h expected %h", $time, what, got, want);
  endtask

  // Monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    coef_t e;
    if (rst_n && out_valid) begin
      if (coef_q.size() == 0) begin
        report_mismatch("result with nothing expected", out_coef_value, 64'd0);
      end else begin
        e = coef_q.pop_front();
        checked++;
        if (out_coef_index !== e.index) report_mismatch("coef_index", out_coef_index, e.index);
        if (out_coef_value !== e.value) report_mismatch("coef_value", out_coef_value, e.value);
        if (out_status !== e.status) report_mismatch("status", out_status, e.status);
        if (out_last !== e.last) report_mismatch("last", out_last, e.last);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_item(logic [1:0] m, logic [3:0] r, logic [3:0] c, logic [63:0] v);
    pending_q.push_back('{m, r, c, v});
    if (m != MODE_NONE && !(m == MODE_LOAD_BASIS && c > r)) items_pushed++;
    if (m == MODE_LOAD_POLY) poly_set[r] = 1'b1;
    if (m == MODE_LOAD_BASIS && c <= r) basis_set[r][c] = 1'b1;
  endtask

  // Sender drains, then the unit must stay quiet for a while
  task automatic wait_idle();
    int quiet;
    quiet = 0;
    while (quiet < SETTLE) begin
      @(posedge clk);
      if (pending_q.size() == 0 && !start && !busy && coef_q.size() == 0) quiet++;
      else quiet = 0;
    end
  endtask

  task automatic cfg_write(logic [2:0] addr, logic [4:0] v);
    wait_idle();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= {27'($urandom_range(0, 7)), v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_PLEN) cfg_plen = v;
    else cfg_bsize = v;
  endtask

  function automatic logic [63:0] small_val();
    return $signed({$urandom, $urandom}) >>> 8;
  endfunction

  function automatic logic [63:0] any_val();
    case ($urandom_range(0, 5))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return 64'd0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] diag_val();
    logic [63:0] v;
    v = Q_ONE + ({$urandom, $urandom} >> 9);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // One expansion: refresh needed entries (some always), noise, then start
  task automatic gen_run(bit rough);
    int p, b;
    p = eff_plen(cfg_plen);
    b = eff_bsize(cfg_bsize);
    if (p <= b) begin
      for (int r = 0; r < p; r++) begin
        if (!poly_set[r] || $urandom_range(0, 1))
          push_item(MODE_LOAD_POLY, 4'(r), 4'($urandom), rough ? any_val() : small_val());
        for (int c = 0; c <= r; c++) begin
          if (!basis_set[r][c] || $urandom_range(0, 2) == 0) begin
            if (c == r)
              push_item(MODE_LOAD_BASIS, 4'(r), 4'(c), rough ? any_val()
                        : ($urandom_range(0, 15) == 0 ? 64'd0 : diag_val()));
            else
              push_item(MODE_LOAD_BASIS, 4'(r), 4'(c), rough ? any_val() : small_val());
          end
        end
      end
    end
    if ($urandom_range(0, 3) == 0)
      push_item(MODE_NONE, 4'($urandom), 4'($urandom), any_val());
    if ($urandom_range(0, 3) == 0)
      push_item(MODE_LOAD_BASIS, 4'd3, 4'(4 + $urandom_range(0, 11)), any_val());
    push_item(MODE_START, 4'($urandom), 4'($urandom), {$urandom, $urandom});
  endtask

  task automatic run_phase(logic [4:0] pl, logic [4:0] bs, int nruns);
    cfg_write(ADDR_PLEN, pl);
    cfg_write(ADDR_BSZ, bs);
    for (int i = 0; i < nruns; i++) gen_run($urandom_range(0, 7) == 0);
  endtask

  initial begin
    logic [4:0] pl, bs;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: single-term runs at reset settings, extremes and zero divisor
    push_item(MODE_LOAD_POLY, 4'd0, 4'd0, Q_ONE);
    push_item(MODE_LOAD_BASIS, 4'd0, 4'd0, Q_ONE);
    push_item(MODE_START, 4'd0, 4'd0, 64'd0);
    push_item(MODE_LOAD_POLY, 4'd0, 4'd15, Q_MAX);
    push_item(MODE_LOAD_BASIS, 4'd0, 4'd0, 64'h0080_0000_0000_0000);
    push_item(MODE_START, 4'd15, 4'd15, Q_MAX);
    push_item(MODE_LOAD_BASIS, 4'd0, 4'd0, 64'd0);
    push_item(MODE_START, 4'd0, 4'd0, 64'd0);
    push_item(MODE_LOAD_POLY, 4'd0, 4'd0, Q_MIN);
    push_item(MODE_START, 4'd0, 4'd0, Q_MIN);
    push_item(MODE_LOAD_POLY, 4'd0, 4'd0, 64'd0);
    push_item(MODE_START, 4'd0, 4'd0, 64'd0);
    push_item(MODE_NONE, 4'd15, 4'd15, Q_MAX);
    push_item(MODE_LOAD_BASIS, 4'd2, 4'd15, Q_MIN);
    push_item(MODE_LOAD_POLY, 4'd0, 4'd0, Q_MIN);
    push_item(MODE_LOAD_BASIS, 4'd0, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    push_item(MODE_START, 4'd0, 4'd0, 64'd0);
    // Polynomial longer than basis, empty polynomial, clamped registers
    cfg_write(ADDR_PLEN, 5'd3);
    cfg_write(ADDR_BSZ, 5'd2);
    push_item(MODE_START, 4'd0, 4'd0, 64'd0);
    cfg_write(ADDR_PLEN, 5'd0);
    cfg_write(ADDR_BSZ, 5'd0);
    push_item(MODE_START, 4'd0, 4'd0, 64'd0);

    // Largest size, a few runs only
    run_phase(5'd31, 5'd31, 1);
    run_phase(5'd16, 5'd16, 2);
    run_phase(5'd1, 5'd1, 3);
    run_phase(5'd16, 5'd1, 1);

    // Random settings, mostly small
    while (items_pushed < 380) begin
      pl = 5'($urandom_range(1, 6));
      bs = ($urandom_range(0, 5) == 0) ? pl - 5'd1 : 5'($urandom_range(pl, 16));
      run_phase(pl, bs, $urandom_range(2, 5));
    end

    // Last stretch with no idle gaps
    wait_idle();
    gaps_on = 1'b0;
    run_phase(5'd4, 5'd8, 4);
    wait_idle();

    $display("Covered %0d expansion runs (%0d saturated), %0d load/start transactions,",
             runs_done, sat_runs, items_pushed);
    $display("%0d coefficients checked, register settings from 0 up to 31.", checked);
    if (errors == 0 && coef_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
